// File: hw/rtl/axis_angle_rotation_matrix_core_macros.svh
// assertion macros used by the rtl core
`ifndef AXIS_ANGLE_ROTATION_MATRIX_CORE_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_CORE_MACROS_SVH

// plain implication checked on every edge out of reset
`define AARM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define AARM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/aarm_pkg.sv
package aarm_pkg;
    localparam int CordicStagesDef = 16;
    localparam int AxisFracBitsDef = 14;
    localparam int OutFracBitsDef  = 16;
    localparam int AngW   = 16;
    localparam int AxisW  = 16;
    localparam int OutW   = 20;
    localparam int TrigFrac = 22;
    localparam int CordW  = 34;
    localparam int AtanCount = 24;
    localparam int DegFull = 23040;
    localparam int DegHalf = 11520;
    localparam int DegQuarter = 5760;
    localparam longint PiQ29 = 64'd1686629713;
    localparam longint GainQ30 = 64'd652032874;
    localparam longint OutMax = 64'sd524287;
    localparam longint OutMin = -64'sd524288;

    typedef logic signed [CordW-1:0] t_cord;
    typedef logic signed [24:0] t_trig;

    function automatic t_cord atan_q30(input int i);
        logic [29:0] v;
        begin
            case (i)
                0: v = 30'd843314856;  1: v = 30'd497837829;
                2: v = 30'd263043836;  3: v = 30'd133525158;
                4: v = 30'd67021686;   5: v = 30'd33543515;
                6: v = 30'd16775850;   7: v = 30'd8388437;
                8: v = 30'd4194282;    9: v = 30'd2097149;
                10: v = 30'd1048575;   11: v = 30'd524287;
                12: v = 30'd262143;    13: v = 30'd131071;
                14: v = 30'd65535;     15: v = 30'd32767;
                16: v = 30'd16383;     17: v = 30'd8191;
                18: v = 30'd4095;      19: v = 30'd2047;
                20: v = 30'd1023;      21: v = 30'd511;
                22: v = 30'd255;       default: v = 30'd127;
            endcase
            atan_q30 = t_cord'({4'b0, v});
        end
    endfunction
endpackage

// File: hw/rtl/aarm_if.sv
interface aarm_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/aarm_trig.sv
// angle reduction, radian scaling and cordic; advances when i_en
module aarm_trig import aarm_pkg::*; #(
    parameter int CORDIC_STAGES = CordicStagesDef
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_angle,
    output logic signed [24:0]  o_c,
    output logic signed [24:0]  o_s
);
    localparam int NS = (CORDIC_STAGES < AtanCount) ? CORDIC_STAGES : AtanCount;

    // stage a: reduction
    logic signed [17:0] w_m0, w_m1, w_m;
    logic               w_flip;
    always_comb begin
        w_m0 = 18'(i_angle);
        if (w_m0 >= 18'sd11520) w_m1 = w_m0 - 18'sd23040;
        else if (w_m0 < -18'sd11520) w_m1 = w_m0 + 18'sd23040;
        else w_m1 = w_m0;
        w_flip = 1'b0;
        w_m = w_m1;
        if (w_m1 > 18'sd5760) begin
            w_m = w_m1 - 18'sd11520;
            w_flip = 1'b1;
        end else if (w_m1 < -18'sd5760) begin
            w_m = w_m1 + 18'sd11520;
            w_flip = 1'b1;
        end
    end
    logic [12:0] r_mag;
    logic        r_neg, r_flip0;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= 13'(w_m < 0 ? -w_m : w_m);
            r_neg <= w_m < 0;
            r_flip0 <= w_flip;
        end
    end

    // stage b: multiply by pi
    logic [43:0] r_prod;
    logic        r_neg1, r_flip1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 44'(r_mag) * 44'(PiQ29) + 44'(DegQuarter / 2);
            r_neg1 <= r_neg;
            r_flip1 <= r_flip0;
        end
    end

    // stage c: divide by 5760 = 45 << 7, reciprocal multiply and correction
    logic [36:0] w_q7;
    logic [31:0] w_qe;
    logic [37:0] w_rem;
    logic [31:0] w_q;
    always_comb begin
        w_q7 = r_prod[43:7];
        w_qe = 32'((72'(w_q7) * 72'd1527099483) >> 36);
        w_rem = 38'(w_q7) - 38'(w_qe) * 38'd45;
        w_q = (w_rem >= 38'd45) ? w_qe + 32'd1 : w_qe;
    end
    t_cord r_z0;
    logic  r_flip2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0 <= r_neg1 ? -t_cord'(w_q) : t_cord'(w_q);
            r_flip2 <= r_flip1;
        end
    end

    // cordic stages
    t_cord r_x [0:NS];
    t_cord r_y [0:NS];
    t_cord r_z [0:NS];
    logic  r_fl [0:NS];
    always_comb begin
        r_x[0] = t_cord'(GainQ30);
        r_y[0] = '0;
        r_z[0] = r_z0;
        r_fl[0] = r_flip2;
    end
    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_st
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_z[g] >= 0) begin
                        r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                        r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                        r_z[g+1] <= r_z[g] - atan_q30(g);
                    end else begin
                        r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                        r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                        r_z[g+1] <= r_z[g] + atan_q30(g);
                    end
                    r_fl[g+1] <= r_fl[g];
                end
            end
        end
    endgenerate

    // rounding to q22
    t_cord w_cr, w_sr;
    always_comb begin
        w_cr = (r_x[NS] + t_cord'(128)) >>> 8;
        w_sr = (r_y[NS] + t_cord'(128)) >>> 8;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_c <= r_fl[NS] ? -25'(w_cr) : 25'(w_cr);
            o_s <= r_fl[NS] ? -25'(w_sr) : 25'(w_sr);
        end
    end
endmodule

// File: hw/rtl/aarm_matrix.sv
// axis products and rodrigues entries; latency matched to the trig path
module aarm_matrix import aarm_pkg::*; #(
    parameter int CORDIC_STAGES  = CordicStagesDef,
    parameter int AXIS_FRAC_BITS = AxisFracBitsDef,
    parameter int OUT_FRAC_BITS  = OutFracBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [15:0]    i_x,
    input  logic signed [15:0]    i_y,
    input  logic signed [15:0]    i_z,
    input  logic signed [24:0]    i_c,
    input  logic signed [24:0]    i_s,
    output logic [9*OutW-1:0]     o_e,
    output logic                  o_sat
);
    localparam int NS = (CORDIC_STAGES < AtanCount) ? CORDIC_STAGES : AtanCount;
    localparam int DLY = NS + 4;
    localparam int SH = 2 * AXIS_FRAC_BITS + TrigFrac - OUT_FRAC_BITS;
    localparam int PW = 64;

    // axis delay line so it meets c and s
    logic signed [15:0] r_dx [0:DLY-1];
    logic signed [15:0] r_dy [0:DLY-1];
    logic signed [15:0] r_dz [0:DLY-1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx[0] <= i_x;
            r_dy[0] <= i_y;
            r_dz[0] <= i_z;
            for (int k = 1; k < DLY; k++) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
                r_dz[k] <= r_dz[k-1];
            end
        end
    end
    logic signed [15:0] w_x, w_y, w_z;
    assign w_x = r_dx[DLY-1];
    assign w_y = r_dy[DLY-1];
    assign w_z = r_dz[DLY-1];

    // stage 1: pair products and scaled sine terms
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [40:0] r_xs, r_ys, r_zs;
    logic signed [25:0] r_a;
    logic signed [24:0] r_c;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= w_x * w_x; r_yy <= w_y * w_y; r_zz <= w_z * w_z;
            r_xy <= w_x * w_y; r_xz <= w_x * w_z; r_yz <= w_y * w_z;
            r_xs <= 41'(w_x) * 41'(i_s);
            r_ys <= 41'(w_y) * 41'(i_s);
            r_zs <= 41'(w_z) * 41'(i_s);
            r_a <= 26'sd4194304 - 26'(i_c);
            r_c <= i_c;
        end
    end

    // stage 2: times a
    logic signed [PW-1:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [PW-1:0] r_xs2, r_ys2, r_zs2, r_cs2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxx <= PW'(r_xx) * PW'(r_a); r_pyy <= PW'(r_yy) * PW'(r_a);
            r_pzz <= PW'(r_zz) * PW'(r_a); r_pxy <= PW'(r_xy) * PW'(r_a);
            r_pxz <= PW'(r_xz) * PW'(r_a); r_pyz <= PW'(r_yz) * PW'(r_a);
            r_xs2 <= PW'(r_xs) <<< AXIS_FRAC_BITS;
            r_ys2 <= PW'(r_ys) <<< AXIS_FRAC_BITS;
            r_zs2 <= PW'(r_zs) <<< AXIS_FRAC_BITS;
            r_cs2 <= PW'(r_c) <<< (2 * AXIS_FRAC_BITS);
        end
    end

    // stage 3: sums
    logic signed [PW-1:0] r_sum [0:8];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum[0] <= r_pxx + r_cs2;
            r_sum[1] <= r_pxy + r_zs2;
            r_sum[2] <= r_pxz - r_ys2;
            r_sum[3] <= r_pxy - r_zs2;
            r_sum[4] <= r_pyy + r_cs2;
            r_sum[5] <= r_pyz + r_xs2;
            r_sum[6] <= r_pxz + r_ys2;
            r_sum[7] <= r_pyz - r_xs2;
            r_sum[8] <= r_pzz + r_cs2;
        end
    end

    // stage 4: round and saturate
    logic signed [PW-1:0] w_r [0:8];
    logic [OutW-1:0]      w_o [0:8];
    logic [8:0]           w_cl;
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_r[k] = (r_sum[k] + (PW'(1) <<< (SH - 1))) >>> SH;
            w_cl[k] = 1'b1;
            if (w_r[k] > OutMax) w_o[k] = OutW'(OutMax);
            else if (w_r[k] < OutMin) w_o[k] = OutW'(OutMin);
            else begin
                w_o[k] = w_r[k][OutW-1:0];
                w_cl[k] = 1'b0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) o_e[k*OutW +: OutW] <= w_o[k];
            o_sat <= |w_cl;
        end
    end
endmodule

// File: hw/rtl/axis_angle_rotation_matrix_core.sv
// axis-angle rotation matrix, rodrigues form, fixed point
// input channel s_req carries {axis_z, axis_y, axis_x, angle}, angle in
// 1/64 degree, axis components signed with AXIS_FRAC_BITS fraction bits
// output channel m_res carries {saturated, entry_8 .. entry_0}, nine
// entries of 20 bits each with OUT_FRAC_BITS fraction bits
// from request to result the data passes reduction, pi multiply,
// reciprocal division, a register for each cordic rotation, rounding,
// then the registered products and sums; throughput while not stalled:
// one request per cycle, set by the fully pipelined cordic
// a stall on the output freezes the whole pipeline together with its
// valid bits; ready toward the source is high out of reset while the last
// stage is empty or being taken, so nothing is lost or repeated
// reset clears only the valid bits and holds ready low; the data registers
// of the pipeline are not cleared by reset
`include "axis_angle_rotation_matrix_core_macros.svh"
module axis_angle_rotation_matrix_core import aarm_pkg::*; #(
    parameter int CORDIC_STAGES  = CordicStagesDef,
    parameter int AXIS_FRAC_BITS = AxisFracBitsDef,
    parameter int OUT_FRAC_BITS  = OutFracBitsDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    aarm_if.sink   s_req,
    aarm_if.source m_res
);
    localparam int NS = (CORDIC_STAGES < AtanCount) ? CORDIC_STAGES : AtanCount;
    localparam int LAT = NS + 8;

    // global pipeline advance
    logic w_en;
    logic [LAT-1:0] r_vld;
    assign w_en = !r_vld[LAT-1] || m_res.ready;
    assign s_req.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_req.valid};
        end
    end

    logic signed [24:0] w_c, w_s;
    aarm_trig #(.CORDIC_STAGES(CORDIC_STAGES)) u_trig (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (s_req.data[15:0]),
        .o_c     (w_c),
        .o_s     (w_s)
    );

    logic [9*OutW-1:0] w_e;
    logic              w_sat;
    aarm_matrix #(
        .CORDIC_STAGES  (CORDIC_STAGES),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_mat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (s_req.data[31:16]),
        .i_y   (s_req.data[47:32]),
        .i_z   (s_req.data[63:48]),
        .i_c   (w_c),
        .i_s   (w_s),
        .o_e   (w_e),
        .o_sat (w_sat)
    );

    assign m_res.valid = r_vld[LAT-1];
    assign m_res.data = {w_sat, w_e};

    `AARM_ASSERT(a_rdy, i_clk, i_rst_n, !m_res.valid |-> s_req.ready, "ready low with empty output")
    `AARM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_res.valid && !m_res.ready, m_res.valid && $stable(m_res.data), "stalled result changed")
    `AARM_ASSERT_NEXT(a_move, i_clk, i_rst_n, s_req.valid && s_req.ready, r_vld[0], "request lost at entry")
endmodule
